// File: rtl/core/rtds_pkg.sv
// ----------------------------------------------------------------------------
// rtds_pkg: shared types and constants
// Phase encoding, transaction kinds, register indexes and display constants
// for the reaction timer with multiplexed display.
// ----------------------------------------------------------------------------
package rtds_pkg;

    // Transaction kinds on the input channel
    localparam logic [1:0] KIND_CENTI   = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_PRESS   = 2'd2;

    // Phase codes as seen on the output port
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_DELAY = 2'd1;
    localparam logic [1:0] PHASE_RUN   = 2'd2;
    localparam logic [1:0] PHASE_STOP  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TARGET_BUTTON = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DELAY_TICKS   = 2'd1;

    localparam logic [2:0]  START_BUTTON       = 3'd7;
    localparam logic [2:0]  TARGET_RESET       = 3'd0;
    localparam logic [15:0] DELAY_TICKS_RESET  = 16'd200;
    localparam logic [6:0]  COUNT_MAX          = 7'd99;

    localparam logic [3:0] SELECT_BLANK  = 4'hF;
    localparam logic [7:0] SEGMENT_BLANK = 8'hFF;
    localparam logic [7:0] SEGMENT_BASE  = 8'hF0;
    localparam logic [7:0] DOT_MASK      = 8'h7F;

    // Digit scan positions
    localparam logic [1:0] POS_CENTI_UNITS = 2'd0;
    localparam logic [1:0] POS_CENTI_TENS  = 2'd1;
    localparam logic [1:0] POS_SEC_UNITS   = 2'd2;
    localparam logic [1:0] POS_SEC_TENS    = 2'd3;

    // Internal one-hot phase state
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DELAY = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_STOP  = 4'b1000
    } phase_state_t;

    // What one refresh drives onto the display
    typedef struct packed {
        logic [3:0] digit_select;
        logic [7:0] segment_code;
    } scan_drive_t;

endpackage

// File: rtl/core/rtds_scan.sv
// ----------------------------------------------------------------------------
// rtds_scan: display scan decode
// Picks the digit for the current scan position and builds the active-low
// select and the segment byte, with the dot on the seconds units digit.
// ----------------------------------------------------------------------------
module rtds_scan
    import rtds_pkg::*;
(
    input  logic [1:0]  scan_position,
    input  logic [6:0]  centi_count,
    input  logic [6:0]  second_count,
    output scan_drive_t drive
);

    logic [6:0]  value;
    logic [17:0] product;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic [7:0]  tens_x10;
    logic [3:0]  digit;
    logic [7:0]  code;

    assign value = scan_position[1] ? second_count : centi_count;

    // value / 10 as (value * 205) >> 11, exact for every 7-bit value
    assign product  = {11'd0, value} * 18'd205;
    assign tens     = product[14:11];
    assign tens_x10 = {tens, 3'd0} + {3'd0, tens, 1'b0};
    assign units    = 4'(({1'b0, value}) - tens_x10);

    assign digit = scan_position[0] ? tens : units;
    assign code  = SEGMENT_BASE + {4'd0, digit};

    always_comb
    begin
        unique case (scan_position)
            POS_CENTI_UNITS:
            begin
                drive.digit_select = 4'hE;
                drive.segment_code = code;
            end
            POS_CENTI_TENS:
            begin
                drive.digit_select = 4'hD;
                drive.segment_code = code;
            end
            POS_SEC_UNITS:
            begin
                drive.digit_select = 4'hB;
                drive.segment_code = code & DOT_MASK;
            end
            default:
            begin
                drive.digit_select = 4'h7;
                drive.segment_code = code;
            end
        endcase
    end

endmodule

// File: rtl/core/reaction_timer_with_display_scan.sv
// ----------------------------------------------------------------------------
// reaction_timer_with_display_scan: reaction-time tester top level
// Phase control, delay counter, stopwatch, display scan and output register.
// ----------------------------------------------------------------------------
// Each input transaction (centisecond tick, refresh tick or button press)
// loads the state registers and the result register at the same edge, so a
// new transaction is taken every cycle while the result register is empty
// or being drained. The one result register is what sets that figure; when
// the consumer stalls, in_ready drops until the waiting result is taken.
// Pressing button 7 in idle starts the delay; after
// delay_ticks centisecond ticks (zero acts as one) the LED of target_button
// lights and the stopwatch runs in hundredths and seconds, seconds wrapping
// at 100. The target button stops it; button 7 while stopped clears all and
// blanks the display. Refresh ticks outside idle walk four active-low digit
// selects, each with segment code 0xF0 plus the digit, the dot on seconds
// units. The configuration port is always ready; writes are meant to land
// only while no transaction is in flight, and unknown indexes are dropped.
// ----------------------------------------------------------------------------
module reaction_timer_with_display_scan
    import rtds_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [15:0]                cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 kind,
    input  logic [2:0]                 button,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 phase,
    output logic [7:0]                 led_mask,
    output logic [3:0]                 digit_select,
    output logic [7:0]                 segment_code,
    output logic [6:0]                 hundredths,
    output logic [6:0]                 seconds_shown
);

    // Configuration registers
    logic [2:0]   target_reg;
    logic [15:0]  delay_ticks_reg;

    // Block state
    phase_state_t state_reg,  state_next;
    logic [15:0]  delay_reg,  delay_next;
    logic [6:0]   centi_reg,  centi_next;
    logic [6:0]   second_reg, second_next;
    logic [1:0]   scan_reg,   scan_next;
    logic [3:0]   select_reg, select_next;
    logic [7:0]   seg_reg,    seg_next;

    // Result register
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   phase_reg,  phase_next;
    logic [7:0]   led_reg,    led_next;
    logic [3:0]   dsel_reg;
    logic [7:0]   scode_reg;
    logic [6:0]   hund_reg;
    logic [6:0]   secs_reg;

    logic         in_fire;
    logic         out_fire;
    logic [15:0]  delay_inc;
    scan_drive_t  drive;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= TARGET_RESET;
            delay_ticks_reg <= DELAY_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TARGET_BUTTON)
                target_reg <= cfg_data[2:0];
            else if (cfg_index == CFG_DELAY_TICKS)
                delay_ticks_reg <= cfg_data;
        end
    end

    // Segment and select for the current scan position
    rtds_scan u_scan
    (
        .scan_position (scan_reg),
        .centi_count   (centi_reg),
        .second_count  (second_reg),
        .drive         (drive)
    );

    assign delay_inc = delay_reg + 16'd1;

    // Next state for one transaction
    always_comb
    begin
        state_next  = state_reg;
        delay_next  = delay_reg;
        centi_next  = centi_reg;
        second_next = second_reg;
        scan_next   = scan_reg;
        select_next = select_reg;
        seg_next    = seg_reg;

        unique case (kind)
            KIND_CENTI:
            begin
                if (state_reg == ST_DELAY)
                begin
                    delay_next = delay_inc;
                    if (delay_inc >= delay_ticks_reg)
                        state_next = ST_RUN;
                end
                else if (state_reg == ST_RUN)
                begin
                    if (centi_reg >= COUNT_MAX)
                    begin
                        centi_next  = '0;
                        second_next = (second_reg >= COUNT_MAX) ? 7'd0 : second_reg + 7'd1;
                    end
                    else
                    begin
                        centi_next = centi_reg + 7'd1;
                    end
                end
            end
            KIND_REFRESH:
            begin
                // Display stays blank in idle
                if (state_reg != ST_IDLE)
                begin
                    select_next = drive.digit_select;
                    seg_next    = drive.segment_code;
                    scan_next   = scan_reg + 2'd1;
                end
            end
            KIND_PRESS:
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (button == START_BUTTON)
                        begin
                            state_next = ST_DELAY;
                            delay_next = '0;
                        end
                    end
                    ST_RUN:
                    begin
                        if (button == target_reg)
                            state_next = ST_STOP;
                    end
                    ST_STOP:
                    begin
                        // Start press while stopped: back to the reset picture
                        if (button == START_BUTTON)
                        begin
                            state_next  = ST_IDLE;
                            delay_next  = '0;
                            centi_next  = '0;
                            second_next = '0;
                            scan_next   = POS_CENTI_UNITS;
                            select_next = SELECT_BLANK;
                            seg_next    = SEGMENT_BLANK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Result fields derived from the updated phase
    always_comb
    begin
        unique case (state_next)
            ST_IDLE:  phase_next = PHASE_IDLE;
            ST_DELAY: phase_next = PHASE_DELAY;
            ST_RUN:   phase_next = PHASE_RUN;
            default:  phase_next = PHASE_STOP;
        endcase
        if (state_next == ST_RUN || state_next == ST_STOP)
            led_next = 8'd1 << target_reg;
        else
            led_next = '0;
    end

    always_comb
    begin
        priority if (in_fire)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            delay_reg     <= '0;
            centi_reg     <= '0;
            second_reg    <= '0;
            scan_reg      <= POS_CENTI_UNITS;
            select_reg    <= SELECT_BLANK;
            seg_reg       <= SEGMENT_BLANK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                state_reg  <= state_next;
                delay_reg  <= delay_next;
                centi_reg  <= centi_next;
                second_reg <= second_next;
                scan_reg   <= scan_next;
                select_reg <= select_next;
                seg_reg    <= seg_next;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            phase_reg <= phase_next;
            led_reg   <= led_next;
            dsel_reg  <= select_next;
            scode_reg <= seg_next;
            hund_reg  <= centi_next;
            secs_reg  <= second_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = phase_reg;
    assign led_mask      = led_reg;
    assign digit_select  = dsel_reg;
    assign segment_code  = scode_reg;
    assign hundredths    = hund_reg;
    assign seconds_shown = secs_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: reaction timer with display scan, self-checking bench
// Drives tick, refresh and press transactions with random gaps and output
// stalls, predicts every reading in a small scoreboard class, and compares
// each reading field by field. Covers register extremes, the hundredths wrap
// and a delay limit lowered part way through the delay.
// ----------------------------------------------------------------------------
module tb_top
    import rtds_pkg::*;
();

    // Unused transaction kind and the two register indexes with no register
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] led_mask;
        logic [3:0] digit_select;
        logic [7:0] segment_code;
        logic [6:0] hundredths;
        logic [6:0] seconds_shown;
    } timer_reading_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the timer state and the registers,
    // works out the reading each accepted transaction should produce and
    // checks readings against them in order.
    // ------------------------------------------------------------------------
    class reaction_scoreboard;
        logic [2:0]  target;
        logic [15:0] delay_limit;
        logic [1:0]  phase_now;
        logic [15:0] delay_count;
        logic [6:0]  centi;
        logic [6:0]  secs;
        logic [1:0]  scan_pos;
        logic [3:0]  shown_sel;
        logic [7:0]  shown_seg;
        timer_reading_t pending_readings[$];
        int          readings_seen;
        int          errors;

        function new();
            target        = TARGET_RESET;
            delay_limit   = DELAY_TICKS_RESET;
            readings_seen = 0;
            errors        = 0;
            clear_timer();
        endfunction

        function void clear_timer();
            phase_now   = PHASE_IDLE;
            delay_count = '0;
            centi       = '0;
            secs        = '0;
            scan_pos    = POS_CENTI_UNITS;
            shown_sel   = SELECT_BLANK;
            shown_seg   = SEGMENT_BLANK;
        endfunction

        function void write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_TARGET_BUTTON: target      = data[2:0];
                CFG_DELAY_TICKS:   delay_limit = data;
                default: ;
            endcase
        endfunction

        // Apply one accepted input transaction and queue the reading it gives
        function void note_input(logic [1:0] kind_in, logic [2:0] button_in);
            timer_reading_t r;
            logic [3:0]     digit;
            logic [7:0]     code;
            case (kind_in)
                KIND_CENTI: begin
                    if (phase_now == PHASE_DELAY) begin
                        delay_count = delay_count + 16'd1;
                        // a limit of zero, or one lowered below the count, fires here
                        if (delay_count >= delay_limit)
                            phase_now = PHASE_RUN;
                    end
                    else if (phase_now == PHASE_RUN) begin
                        if (centi == COUNT_MAX) begin
                            centi = '0;
                            secs  = (secs == COUNT_MAX) ? 7'd0 : secs + 7'd1;
                        end
                        else
                            centi = centi + 7'd1;
                    end
                end
                KIND_REFRESH: begin
                    if (phase_now != PHASE_IDLE) begin
                        case (scan_pos)
                            POS_CENTI_UNITS: digit = 4'(centi % 7'd10);
                            POS_CENTI_TENS:  digit = 4'(centi / 7'd10);
                            POS_SEC_UNITS:   digit = 4'(secs % 7'd10);
                            default:         digit = 4'(secs / 7'd10);
                        endcase
                        code = SEGMENT_BASE + 8'(digit);
                        if (scan_pos == POS_SEC_UNITS)
                            code = code & DOT_MASK;
                        shown_seg = code;
                        shown_sel = ~(4'b0001 << scan_pos);
                        scan_pos  = scan_pos + 2'd1;
                    end
                end
                KIND_PRESS: begin
                    case (phase_now)
                        PHASE_IDLE:
                            if (button_in == START_BUTTON) begin
                                phase_now   = PHASE_DELAY;
                                delay_count = '0;
                            end
                        PHASE_RUN:
                            if (button_in == target)
                                phase_now = PHASE_STOP;
                        PHASE_STOP:
                            if (button_in == START_BUTTON)
                                clear_timer();
                        default: ;
                    endcase
                end
                default: ;
            endcase

            r.phase         = phase_now;
            r.led_mask      = (phase_now == PHASE_RUN || phase_now == PHASE_STOP)
                              ? (8'd1 << target) : 8'd0;
            r.digit_select  = shown_sel;
            r.segment_code  = shown_seg;
            r.hundredths    = centi;
            r.seconds_shown = secs;
            pending_readings.push_back(r);
        endfunction

        function void check_result(timer_reading_t got);
            timer_reading_t want;
            readings_seen++;
            if (pending_readings.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: reading %0d arrived with nothing expected", readings_seen);
                return;
            end
            want = pending_readings.pop_front();
            if (got.phase !== want.phase || got.led_mask !== want.led_mask ||
                got.digit_select !== want.digit_select ||
                got.segment_code !== want.segment_code ||
                got.hundredths !== want.hundredths ||
                got.seconds_shown !== want.seconds_shown) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: reading %0d: expected phase=%0d led=%02h sel=%h ",
                              "seg=%02h cs=%0d s=%0d, got phase=%0d led=%02h sel=%h ",
                              "seg=%02h cs=%0d s=%0d"},
                             readings_seen, want.phase, want.led_mask, want.digit_select,
                             want.segment_code, want.hundredths, want.seconds_shown,
                             got.phase, got.led_mask, got.digit_select,
                             got.segment_code, got.hundredths, got.seconds_shown);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input is known from time zero
    // ------------------------------------------------------------------------
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [15:0]                cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [1:0]                 kind      = '0;
    logic [2:0]                 button    = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 phase;
    logic [7:0]                 led_mask;
    logic [3:0]                 digit_select;
    logic [7:0]                 segment_code;
    logic [6:0]                 hundredths;
    logic [6:0]                 seconds_shown;

    reaction_scoreboard sb;
    bit no_idle    = 1'b0;  // set for stretches run flat out on both sides
    int stall_left = 0;

    reaction_timer_with_display_scan DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .button        (button),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .phase         (phase),
        .led_mask      (led_mask),
        .digit_select  (digit_select),
        .segment_code  (segment_code),
        .hundredths    (hundredths),
        .seconds_shown (seconds_shown)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Consumer side: random stalls on out_ready
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_idle && $urandom_range(0, 99) < 10) begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            out_ready <= 1'b1;
    end

    // Every reading transaction goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(timer_reading_t'{phase, led_mask, digit_select, segment_code,
                                             hundredths, seconds_shown});
    end

    // One input transaction. valid is only lowered when a gap follows, so a
    // back-to-back transaction never sees valid dropped and raised in one step.
    task automatic send_item(input logic [1:0] k, input logic [2:0] b);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        button   <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_input(k, b);
    endtask

    // Hold off the sender until every queued reading has come back. With
    // nothing queued no transaction was just taken, so valid is already low.
    task automatic wait_drained();
        if (sb.pending_readings.size() != 0)
            in_valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Two register writes back to back; valid stays high between them
    task automatic write_pair(input logic [CFG_INDEX_WIDTH-1:0] idx_a, input logic [15:0] data_a,
                              input logic [CFG_INDEX_WIDTH-1:0] idx_b, input logic [15:0] data_b);
        cfg_valid <= 1'b1;
        cfg_index <= idx_a;
        cfg_data  <= data_a;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx_a, data_a);
        cfg_index <= idx_b;
        cfg_data  <= data_b;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx_b, data_b);
        cfg_valid <= 1'b0;
    endtask

    // Next transaction, shaped by the predicted phase so that most sequences
    // go start -> delay -> running -> stopped -> clear, with some noise
    function automatic void pick_event(output logic [1:0] k, output logic [2:0] b);
        int r;
        r = $urandom_range(0, 99);
        b = 3'($urandom_range(0, 7));
        k = KIND_PRESS;
        if (r < 12) begin
            k = 2'($urandom_range(0, 3));
            return;
        end
        case (sb.phase_now)
            PHASE_IDLE:
                if (r < 80)
                    b = START_BUTTON;
                else
                    k = (r < 90) ? KIND_CENTI : KIND_REFRESH;
            PHASE_DELAY:
                if (r < 75)
                    k = KIND_CENTI;
                else if (r < 93)
                    k = KIND_REFRESH;
            PHASE_RUN:
                if (r < 68)
                    k = KIND_CENTI;
                else if (r < 88)
                    k = KIND_REFRESH;
                else if (r >= 97)
                    b = sb.target;
            default:
                if (r < 35)
                    k = KIND_REFRESH;
                else if (r < 50)
                    k = KIND_CENTI;
                else if (r < 75)
                    b = START_BUTTON;
        endcase
    endfunction

    task automatic run_random_items(input int count);
        logic [1:0] k;
        logic [2:0] b;
        for (int i = 0; i < count; i++) begin
            // full pause at mid-phase, and now and then at random
            if (i == count / 2 || $urandom_range(0, 199) == 0)
                wait_drained();
            pick_event(k, b);
            send_item(k, b);
        end
    endtask

    initial begin
        logic [2:0]  tgt;
        logic [15:0] dly;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored transactions in idle, then start
        send_item(KIND_SPARE, 3'd5);
        send_item(KIND_REFRESH, 3'd0);       // idle refresh keeps display blank
        send_item(KIND_CENTI, 3'd0);
        send_item(KIND_PRESS, 3'd0);         // target press in idle is ignored
        send_item(KIND_PRESS, START_BUTTON);
        send_item(KIND_PRESS, START_BUTTON); // presses in delay are ignored
        send_item(KIND_PRESS, 3'd0);
        send_item(KIND_REFRESH, 3'd7);
        send_item(KIND_CENTI, 3'd0);
        send_item(KIND_CENTI, 3'd0);
        // Lower the delay limit below the count mid-delay; target on button 7
        wait_drained();
        write_pair(CFG_DELAY_TICKS, 16'd1, CFG_TARGET_BUTTON, 16'd7);
        send_item(KIND_CENTI, 3'd0);         // straight into running
        send_item(KIND_PRESS, 3'd0);         // not the target
        repeat (4) send_item(KIND_REFRESH, 3'd0);
        send_item(KIND_CENTI, 3'd0);
        send_item(KIND_CENTI, 3'd0);
        send_item(KIND_PRESS, START_BUTTON); // button 7 is the target: stops
        send_item(KIND_CENTI, 3'd0);         // ignored when stopped
        send_item(KIND_REFRESH, 3'd0);
        send_item(KIND_PRESS, 3'd3);         // ignored when stopped
        send_item(KIND_PRESS, START_BUTTON); // clear

        // Writes to indexes with no register behind them
        wait_drained();
        write_pair(CFG_SPARE_A, 16'hFFFF, CFG_SPARE_B, 16'h0000);

        // Random phases under several register settings, extremes first
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin tgt = 3'd7; dly = 16'd0;     end
                1: begin tgt = 3'd6; dly = 16'hFFFF;  end
                2: begin tgt = 3'd0; dly = 16'd1;     end
                default: begin
                    tgt = 3'($urandom_range(0, 7));
                    dly = 16'($urandom_range(1, 40));
                end
            endcase
            wait_drained();
            write_pair(CFG_TARGET_BUTTON, 16'(tgt), CFG_DELAY_TICKS, dly);
            run_random_items(145);
        end

        // Run flat out: hundredths wraps back to zero and seconds count up
        wait_drained();
        write_pair(CFG_TARGET_BUTTON, 16'd5, CFG_DELAY_TICKS, 16'd1);
        while (sb.phase_now != PHASE_IDLE) begin
            case (sb.phase_now)
                PHASE_RUN:  send_item(KIND_PRESS, sb.target);
                PHASE_STOP: send_item(KIND_PRESS, START_BUTTON);
                default:    send_item(KIND_CENTI, 3'd0);
            endcase
        end
        no_idle = 1'b1;
        send_item(KIND_PRESS, START_BUTTON);
        send_item(KIND_CENTI, 3'd0);
        for (int i = 0; i < 250; i++) begin
            send_item(KIND_CENTI, 3'($urandom_range(0, 7)));
            if (i % 41 == 0)
                send_item(KIND_REFRESH, 3'd0);
        end
        send_item(KIND_PRESS, sb.target);
        no_idle = 1'b0;
        send_item(KIND_REFRESH, 3'd0);
        send_item(KIND_PRESS, START_BUTTON);

        // Drain, then let the pipeline settle in case anything extra turns up
        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_readings.size() == 0)
            $display("reaction_timer_with_display_scan: match");
        else
            $display("reaction_timer_with_display_scan: mismatch");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #8_000_000;
        $display("reaction_timer_with_display_scan: mismatch");
        $finish;
    end

endmodule
